/* hw/rtl/bmpcrop_pkg.sv */
package bmpcrop_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // register field widths
    localparam int SIZE_W = 13;
    localparam int POS_W  = 12;

    // byte-column arithmetic (3 * (left + width) peaks near 36.9k) and signed row math
    localparam int SPAN_W = 17;
    localparam int ROWS_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;

    // one passed byte plus the padding that trails it
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] pad_cnt;
        logic       img_end;
    } crop_item_t;

endpackage

/* hw/rtl/bmpcrop_front.sv */
module bmpcrop_front #(
    parameter int MAX_WIDTH  = bmpcrop_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpcrop_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [bmpcrop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmpcrop_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         source_byte,
    input  logic                               fifo_full,
    output logic                               push,
    output bmpcrop_pkg::crop_item_t            push_item
);

    localparam int SIZE_W = bmpcrop_pkg::SIZE_W;
    localparam int POS_W  = bmpcrop_pkg::POS_W;
    localparam int SPAN_W = bmpcrop_pkg::SPAN_W;
    localparam int ROWS_W = bmpcrop_pkg::ROWS_W;
    localparam int COL_W  = $clog2(3 * MAX_WIDTH + 4);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [SIZE_W-1:0] src_width_reg;
    logic [SIZE_W-1:0] src_height_reg;
    logic [POS_W-1:0]  win_left_reg;
    logic [POS_W-1:0]  win_top_reg;
    logic [SIZE_W-1:0] win_width_reg;
    logic [SIZE_W-1:0] win_height_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [SIZE_W-1:0] w_clamp;
    logic [SIZE_W-1:0] h_clamp;
    logic [SPAN_W-1:0] span3_w;
    logic [SPAN_W-1:0] stride;
    logic [SPAN_W-1:0] col_start;
    logic [SPAN_W-1:0] win_sum;
    logic [SPAN_W-1:0] col_end_raw;
    logic [SPAN_W-1:0] col_end;
    logic [SPAN_W-1:0] col_s;
    logic signed [ROWS_W-1:0] row_lo;
    logic signed [ROWS_W-1:0] row_hi;
    logic signed [ROWS_W-1:0] row_s;
    logic        accept;
    logic        pass;
    logic        row_end;
    logic        final_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SIZE_W'(1);
            src_height_reg <= SIZE_W'(1);
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_width_reg  <= SIZE_W'(1);
            win_height_reg <= SIZE_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                bmpcrop_pkg::REG_SOURCE_WIDTH:  src_width_reg  <= cfg_data;
                bmpcrop_pkg::REG_SOURCE_HEIGHT: src_height_reg <= cfg_data;
                bmpcrop_pkg::REG_WINDOW_LEFT:   win_left_reg   <= cfg_data[POS_W-1:0];
                bmpcrop_pkg::REG_WINDOW_TOP:    win_top_reg    <= cfg_data[POS_W-1:0];
                bmpcrop_pkg::REG_WINDOW_WIDTH:  win_width_reg  <= cfg_data;
                bmpcrop_pkg::REG_WINDOW_HEIGHT: win_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (src_width_reg == '0)
            w_clamp = SIZE_W'(1);
        else if (int'(src_width_reg) > MAX_WIDTH)
            w_clamp = SIZE_W'(MAX_WIDTH);
        else
            w_clamp = src_width_reg;

        if (src_height_reg == '0)
            h_clamp = SIZE_W'(1);
        else if (int'(src_height_reg) > MAX_HEIGHT)
            h_clamp = SIZE_W'(MAX_HEIGHT);
        else
            h_clamp = src_height_reg;
    end

    // byte-column window, clipped to the source row
    assign span3_w     = (SPAN_W'(w_clamp) << 1) + SPAN_W'(w_clamp);
    assign stride      = span3_w + SPAN_W'(w_clamp[1:0]);
    assign col_start   = (SPAN_W'(win_left_reg) << 1) + SPAN_W'(win_left_reg);
    assign win_sum     = SPAN_W'(win_left_reg) + SPAN_W'(win_width_reg);
    assign col_end_raw = (win_sum << 1) + win_sum;
    assign col_end     = (col_end_raw > span3_w) ? span3_w : col_end_raw;

    // stored rows, bottom-up; may go negative when the window hangs off the image
    assign row_hi = ROWS_W'(h_clamp) - ROWS_W'(win_top_reg) - ROWS_W'(1);
    assign row_lo = ROWS_W'(h_clamp) - ROWS_W'(win_top_reg) - ROWS_W'(win_height_reg);

    assign col_s = SPAN_W'(col_reg);
    assign row_s = ROWS_W'(row_reg);

    assign pass      = (row_s >= row_lo) && (row_s <= row_hi) &&
                       (col_s >= col_start) && (col_s < col_end);
    assign row_end   = (col_s == col_end - SPAN_W'(1));
    assign final_row = (row_s == row_hi);

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && pass;

    assign push_item.data    = source_byte;
    assign push_item.pad_cnt = row_end ? win_width_reg[1:0] : 2'd0;
    assign push_item.img_end = row_end && final_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_s + SPAN_W'(1) >= stride)
            begin
                col_next = '0;
                if (ROWS_W'(row_reg) + ROWS_W'(1) >= ROWS_W'(h_clamp))
                    row_next = '0;
                else
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hw/rtl/bmpcrop_fifo.sv */
module bmpcrop_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bmpcrop_pkg::crop_item_t push_item,
    input  logic                    pop,
    output logic                    full,
    output logic                    empty,
    output bmpcrop_pkg::crop_item_t head
);

    localparam int DEPTH = bmpcrop_pkg::FIFO_DEPTH;
    localparam int PTR_W = bmpcrop_pkg::FIFO_PTR_W;
    localparam int CNT_W = bmpcrop_pkg::FIFO_CNT_W;

    bmpcrop_pkg::crop_item_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("item pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("item popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

/* hw/rtl/bmpcrop_back.sv */
module bmpcrop_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fifo_empty,
    input  bmpcrop_pkg::crop_item_t head,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              crop_byte,
    output logic                    is_padding,
    output logic                    run_last,
    output logic                    image_last
);

    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic                    out_pad_reg, out_pad_next;
    logic                    out_run_last_reg, out_run_last_next;
    logic                    out_img_last_reg, out_img_last_next;
    logic                    busy_reg, busy_next;
    logic [1:0]              step_reg, step_next;
    bmpcrop_pkg::crop_item_t hold_reg, hold_next;
    logic                    load;
    logic                    last_pad;

    assign load     = !out_valid_reg || out_ready;
    assign last_pad = (step_reg == hold_reg.pad_cnt);
    assign pop      = load && !busy_reg && !fifo_empty;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_byte_next     = out_byte_reg;
        out_pad_next      = out_pad_reg;
        out_run_last_next = out_run_last_reg;
        out_img_last_next = out_img_last_reg;
        busy_next         = busy_reg;
        step_next         = step_reg;
        hold_next         = hold_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                // trailing zero padding of a window row
                out_valid_next    = 1'b1;
                out_byte_next     = 8'd0;
                out_pad_next      = 1'b1;
                out_run_last_next = last_pad;
                out_img_last_next = last_pad && hold_reg.img_end;
                if (last_pad)
                    busy_next = 1'b0;
                else
                    step_next = step_reg + 2'd1;
            end
            else if (!fifo_empty)
            begin
                out_valid_next    = 1'b1;
                out_byte_next     = head.data;
                out_pad_next      = 1'b0;
                out_run_last_next = (head.pad_cnt == 2'd0);
                out_img_last_next = head.img_end && (head.pad_cnt == 2'd0);
                hold_next         = head;
                if (head.pad_cnt != 2'd0)
                begin
                    busy_next = 1'b1;
                    step_next = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            step_reg      <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg     <= out_byte_next;
        out_pad_reg      <= out_pad_next;
        out_run_last_reg <= out_run_last_next;
        out_img_last_reg <= out_img_last_next;
        hold_reg         <= hold_next;
    end

    assign out_valid  = out_valid_reg;
    assign crop_byte  = out_byte_reg;
    assign is_padding = out_pad_reg;
    assign run_last   = out_run_last_reg;
    assign image_last = out_img_last_reg;

    a_pad_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg != 2'd0) && (step_reg <= hold_reg.pad_cnt))
        else $error("padding step outside its run");

    a_no_pop_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !pop)
        else $error("queue popped during a padding run");

    a_img_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_img_last_reg) |-> out_run_last_reg)
        else $error("image end not on the last result of its item");

    a_pad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pad_reg) |-> (out_byte_reg == 8'd0))
        else $error("padding byte not zero");

endmodule

/* hw/rtl/bmp_rgb24_crop_stream.sv */
// An accepted item passes through the item queue to the output register, which holds its first result.
// Throughput: one source byte per cycle; the byte that ends a window row yields
// 1 + window_width % 4 results, one per cycle while out_ready is high, absorbed
// by a 4-entry item queue.
// in_ready drops only when that queue is full.
// Reset: counters, queue and output register clear at once; registers take their defaults.
module bmp_rgb24_crop_stream #(
    parameter int MAX_WIDTH  = bmpcrop_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpcrop_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [bmpcrop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmpcrop_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         source_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         crop_byte,
    output logic                               is_padding,
    output logic                               run_last,
    output logic                               image_last
);

    logic                    fifo_full;
    logic                    fifo_empty;
    logic                    push;
    logic                    pop;
    bmpcrop_pkg::crop_item_t push_item;
    bmpcrop_pkg::crop_item_t head;

    bmpcrop_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_byte  (source_byte),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_item    (push_item)
    );

    bmpcrop_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .head      (head)
    );

    bmpcrop_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .crop_byte  (crop_byte),
        .is_padding (is_padding),
        .run_last   (run_last),
        .image_last (image_last)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int IDX_W  = bmpcrop_pkg::CFG_IDX_W;
    localparam int DATA_W = bmpcrop_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [7:0] data;
        logic       pad;
        logic       run_end;
        logic       img_end;
    } crop_result_t;

    // Tracks the crop window state and holds the crop bytes still owed by the block.
    class crop_scoreboard;
        int unsigned src_w, src_h, win_left, win_top, win_w, win_h;
        int col, row;
        int errors;
        crop_result_t pending[$];

        function new();
            src_w = 1;
            src_h = 1;
            win_left = 0;
            win_top = 0;
            win_w = 1;
            win_h = 1;
            col = 0;
            row = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                bmpcrop_pkg::REG_SOURCE_WIDTH:  src_w = val;
                bmpcrop_pkg::REG_SOURCE_HEIGHT: src_h = val;
                bmpcrop_pkg::REG_WINDOW_LEFT:   win_left = val[bmpcrop_pkg::POS_W-1:0];
                bmpcrop_pkg::REG_WINDOW_TOP:    win_top = val[bmpcrop_pkg::POS_W-1:0];
                bmpcrop_pkg::REG_WINDOW_WIDTH:  win_w = val;
                bmpcrop_pkg::REG_WINDOW_HEIGHT: win_h = val;
                default: ;
            endcase
        endfunction

        function void note_input(logic [7:0] b);
            int w, h, stride, cs, ce, rlo, rhi, pads;
            bit row_end, final_row;
            w = (src_w < 1) ? 1 : ((src_w > bmpcrop_pkg::MAX_WIDTH_DEF) ?
                                   bmpcrop_pkg::MAX_WIDTH_DEF : src_w);
            h = (src_h < 1) ? 1 : ((src_h > bmpcrop_pkg::MAX_HEIGHT_DEF) ?
                                   bmpcrop_pkg::MAX_HEIGHT_DEF : src_h);
            stride = 3 * w + w % 4;
            cs = 3 * win_left;
            ce = 3 * (win_left + win_w);
            if (ce > 3 * w)
                ce = 3 * w;
            rlo = h - win_top - win_h;
            rhi = h - win_top - 1;
            pads = win_w % 4;
            if (row >= rlo && row <= rhi && col >= cs && col < ce) begin
                row_end = (col == ce - 1);
                final_row = (row == rhi);
                pending.push_back({b, 1'b0, !(row_end && pads != 0),
                                   row_end && final_row && pads == 0});
                // padding trails the last window byte of the row
                if (row_end) begin
                    for (int p = 0; p < pads; p++)
                        pending.push_back({8'h00, 1'b1, p == pads - 1,
                                           final_row && p == pads - 1});
                end
            end
            if (col + 1 >= stride) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_result(crop_result_t got);
            crop_result_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected crop byte %h pad %b run_last %b image_last %b",
                                 got.data, got.pad, got.run_end, got.img_end));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                report($sformatf("got byte %h pad %b rl %b il %b, want %h %b %b %b",
                                 got.data, got.pad, got.run_end, got.img_end,
                                 want.data, want.pad, want.run_end, want.img_end));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        source_byte;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        crop_byte;
    logic              is_padding;
    logic              run_last;
    logic              image_last;

    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    crop_scoreboard sb;

    bmp_rgb24_crop_stream i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_byte  (source_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .crop_byte    (crop_byte),
        .is_padding   (is_padding),
        .run_last     (run_last),
        .image_last   (image_last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && out_ready)
            sb.check_result({crop_byte, is_padding, run_last, image_last});
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        source_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(b);
        items_sent++;
        @(negedge clk);
    endtask

    // items outside the window leave nothing to wait for, so give the pipe time to settle
    task wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task apply_config(input logic [DATA_W-1:0] sw, input logic [DATA_W-1:0] sh,
                      input logic [DATA_W-1:0] left, input logic [DATA_W-1:0] top,
                      input logic [DATA_W-1:0] ww, input logic [DATA_W-1:0] wh);
        logic [IDX_W-1:0]  idx [6];
        logic [DATA_W-1:0] val [6];
        idx = '{bmpcrop_pkg::REG_SOURCE_WIDTH, bmpcrop_pkg::REG_SOURCE_HEIGHT,
                bmpcrop_pkg::REG_WINDOW_LEFT, bmpcrop_pkg::REG_WINDOW_TOP,
                bmpcrop_pkg::REG_WINDOW_WIDTH, bmpcrop_pkg::REG_WINDOW_HEIGHT};
        val = '{sw, sh, left, top, ww, wh};
        for (int i = 0; i < 6; i++) begin
            cfg_write_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            sb.write_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] edge_value();
        case ($urandom_range(5))
            0: return DATA_W'(0);
            1: return DATA_W'(1);
            2: return DATA_W'(4095);
            3: return DATA_W'(4096);
            4: return DATA_W'(8191);
            default: return DATA_W'($urandom_range(8191));
        endcase
    endfunction

    initial
    begin
        int phase_no;
        int n;
        logic [DATA_W-1:0] sw, sh, left, top, ww, wh;

        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = bmpcrop_pkg::REG_SOURCE_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        source_byte = 8'h00;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default window over a 1x1 source, running across a frame wrap
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'hFE);
        wait_drained();

        // source size saturates to the legal range
        apply_config(13'd0, 13'd8191, 13'd0, 13'd0, 13'd1, 13'd8191);
        for (int i = 0; i < 4; i++)
            send_byte(8'h55 ^ i[7:0]);
        wait_drained();

        // zero window width passes nothing
        apply_config(13'd2, 13'd2, 13'd0, 13'd0, 13'd0, 13'd2);
        for (int i = 0; i < 3; i++)
            send_byte(8'hA0 + i[7:0]);
        wait_drained();

        // window entirely below the image
        apply_config(13'd2, 13'd2, 13'd0, 13'd2, 13'd2, 13'd1);
        for (int i = 0; i < 3; i++)
            send_byte(8'hC0 + i[7:0]);
        wait_drained();

        // window hangs past the right edge; padding follows the last clipped byte
        apply_config(13'd3, 13'd1, 13'd2, 13'd0, 13'd6, 13'd1);
        for (int i = 0; i < 9; i++)
            send_byte(8'h10 + i[7:0]);
        wait_drained();

        phase_no = 0;
        while (items_sent < 320) begin
            case (phase_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (phase_no == 0) begin
                sw = 13'd4096; sh = 13'd4096; left = 13'd0; top = 13'd0;
                ww = 13'd4096; wh = 13'd4096;
            end else if ($urandom_range(9) == 0) begin
                sw = edge_value(); sh = edge_value(); left = edge_value();
                top = edge_value(); ww = edge_value(); wh = edge_value();
            end else begin
                sw = DATA_W'($urandom_range(1, 6));
                sh = DATA_W'($urandom_range(1, 4));
                left = DATA_W'($urandom_range(0, sw));
                top = DATA_W'($urandom_range(0, sh));
                ww = DATA_W'($urandom_range(0, sw + 1));
                wh = DATA_W'($urandom_range(0, sh + 1));
            end
            apply_config(sw, sh, left, top, ww, wh);
            n = $urandom_range(16, 40);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(255)));
            wait_drained();
            phase_no++;
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
